// File: rtl/crp_pkg.sv
// Package for the radio control response parser.
// Holds the result type, character codes and pattern constants.
// No dependencies; compiled before every other file.
package crp_pkg;

    localparam int FREQ_W = 37;
    localparam int MODE_W = 4;
    localparam int POS_W  = 4;

    typedef logic [7:0]        byte_t;
    typedef logic [FREQ_W-1:0] freq_t;
    typedef logic [MODE_W-1:0] mode_t;
    typedef logic [POS_W-1:0]  pos_t;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_FA   = 2'd1,
        KIND_MD   = 2'd2,
        KIND_ID   = 2'd3
    } kind_t;

    typedef struct packed {
        freq_t frequency_hz;
        mode_t mode_code;
        logic  identity_proven;
        logic  overflow_error;
    } crp_result_t;

    localparam byte_t CH_SPACE = 8'h20;
    localparam byte_t CH_TILDE = 8'h7e;
    localparam byte_t CH_SEMI  = 8'h3b;
    localparam byte_t CH_0     = 8'h30;
    localparam byte_t CH_1     = 8'h31;
    localparam byte_t CH_6     = 8'h36;
    localparam byte_t CH_9     = 8'h39;
    localparam byte_t CH_A     = 8'h41;
    localparam byte_t CH_D     = 8'h44;
    localparam byte_t CH_F     = 8'h46;
    localparam byte_t CH_I     = 8'h49;
    localparam byte_t CH_M     = 8'h4d;

    localparam pos_t POS_MAX     = 4'd15;
    localparam pos_t FA_LAST_POS = 4'd12;
    localparam pos_t FA_DONE_POS = 4'd13;
    localparam pos_t MD_DIG_POS  = 4'd2;
    localparam pos_t MD_DONE_POS = 4'd3;
    localparam pos_t ID_DONE_POS = 4'd5;

    localparam mode_t MODE_NONE        = 4'd0;
    localparam mode_t MODE_DIGIT_CLEAR = 4'd8;
    localparam mode_t MODE_MAX         = 4'd9;

    function automatic byte_t id_char(input logic [2:0] p);
        byte_t c;
        case (p)
            3'd0:    c = CH_I;
            3'd1:    c = CH_D;
            3'd2:    c = CH_0;
            3'd3:    c = CH_0;
            3'd4:    c = CH_6;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// File: rtl/crp_in_if.sv
// Input channel of the response parser: one received byte per item.
// Depends on crp_pkg for the byte type.
interface crp_in_if;
    logic          valid;
    logic          ready;
    crp_pkg::byte_t rx_byte;
    logic          chunk_end;

    modport source (output valid, output rx_byte, output chunk_end, input ready);
    modport sink   (input valid, input rx_byte, input chunk_end, output ready);
endinterface

// File: rtl/crp_out_if.sv
// Result channel of the response parser: frequency, mode and status flags.
// Depends on crp_pkg for the field types.
interface crp_out_if;
    logic          valid;
    logic          ready;
    crp_pkg::freq_t frequency_hz;
    crp_pkg::mode_t mode_code;
    logic          identity_proven;
    logic          overflow_error;

    modport source (output valid, output frequency_hz, output mode_code,
                    output identity_proven, output overflow_error, input ready);
    modport sink   (input valid, input frequency_hz, input mode_code,
                    input identity_proven, input overflow_error, output ready);
endinterface

// File: rtl/crp_parser.sv
// Frame parser state and per-byte update logic of the response parser.
// Depends on crp_pkg; instantiated by cat_response_parser.
module crp_parser #(
    parameter int BUFFER_LIMIT = 4096,
    parameter int FRAME_LIMIT  = 128
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step_en,
    input  crp_pkg::byte_t       rx_byte,
    input  logic                 chunk_end,
    input  logic                 idcheck,
    output logic                 emit,
    output crp_pkg::crp_result_t result
);
    import crp_pkg::*;

    localparam int CNT_W  = $clog2(BUFFER_LIMIT + 1);
    localparam int TRIM_W = $clog2(FRAME_LIMIT + 2);
    localparam logic [CNT_W-1:0]  CNT_LIMIT  = CNT_W'(BUFFER_LIMIT);
    localparam logic [TRIM_W-1:0] TRIM_LIMIT = TRIM_W'(FRAME_LIMIT);

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [TRIM_W-1:0] trim_reg, trim_next;
    logic              lead_reg, lead_next;
    pos_t              pos_reg, pos_next;
    kind_t             kind_reg, kind_next;
    freq_t             acc_reg, acc_next;
    mode_t             pend_reg, pend_next;
    freq_t             freq_reg, freq_next;
    mode_t             mode_reg, mode_next;
    logic              proven_reg, proven_next;
    logic              discard_reg, discard_next;
    logic              overflow;
    mode_t             digit;

    assign digit = rx_byte[MODE_W-1:0];

    always_comb
    begin
        count_next   = count_reg;
        trim_next    = trim_reg;
        lead_next    = lead_reg;
        pos_next     = pos_reg;
        kind_next    = kind_reg;
        acc_next     = acc_reg;
        pend_next    = pend_reg;
        freq_next    = freq_reg;
        mode_next    = mode_reg;
        proven_next  = proven_reg;
        discard_next = discard_reg;
        emit         = 1'b0;
        overflow     = 1'b0;
        if (discard_reg)
        begin
            if (chunk_end)
                discard_next = 1'b0;
        end
        else if (rx_byte inside {[CH_SPACE:CH_TILDE]})
        begin
            if (count_reg >= CNT_LIMIT)
            begin
                count_next   = '0;
                trim_next    = '0;
                lead_next    = 1'b0;
                pos_next     = '0;
                kind_next    = KIND_NONE;
                acc_next     = '0;
                pend_next    = '0;
                discard_next = !chunk_end;
                emit         = 1'b1;
                overflow     = 1'b1;
            end
            else
            begin
                count_next = count_reg + 1'b1;
                if (rx_byte != CH_SEMI)
                begin
                    if (lead_reg || rx_byte != CH_SPACE)
                    begin
                        lead_next = 1'b1;
                        if (pos_reg == '0)
                        begin
                            acc_next = '0;
                            if (rx_byte == CH_F)
                                kind_next = KIND_FA;
                            else if (rx_byte == CH_M)
                                kind_next = KIND_MD;
                            else if (rx_byte == CH_I)
                                kind_next = KIND_ID;
                            else
                                kind_next = KIND_NONE;
                        end
                        else
                        begin
                            case (kind_reg)
                                KIND_FA:
                                begin
                                    if (pos_reg == 4'd1)
                                    begin
                                        if (rx_byte != CH_A)
                                            kind_next = KIND_NONE;
                                    end
                                    else if (pos_reg <= FA_LAST_POS
                                             && rx_byte inside {[CH_0:CH_9]})
                                        acc_next = (acc_reg << 3) + (acc_reg << 1)
                                                   + freq_t'(digit);
                                    else
                                        kind_next = KIND_NONE;
                                end
                                KIND_MD:
                                begin
                                    if (pos_reg == 4'd1)
                                    begin
                                        if (rx_byte != CH_D)
                                            kind_next = KIND_NONE;
                                    end
                                    else if (pos_reg == MD_DIG_POS
                                             && rx_byte inside {[CH_1:CH_9]})
                                        pend_next = digit;
                                    else
                                        kind_next = KIND_NONE;
                                end
                                KIND_ID:
                                begin
                                    if (pos_reg >= ID_DONE_POS
                                        || rx_byte != id_char(pos_reg[2:0]))
                                        kind_next = KIND_NONE;
                                end
                                default: ;
                            endcase
                        end
                        if (pos_reg < POS_MAX)
                            pos_next = pos_reg + 1'b1;
                        if (trim_reg <= TRIM_LIMIT)
                            trim_next = trim_reg + 1'b1;
                    end
                end
                else
                begin
                    if (trim_reg < TRIM_LIMIT)
                    begin
                        if (kind_reg == KIND_FA && pos_reg == FA_DONE_POS)
                            freq_next = acc_reg;
                        else if (kind_reg == KIND_MD && pos_reg == MD_DONE_POS)
                            mode_next = (pend_reg == MODE_DIGIT_CLEAR) ? MODE_NONE : pend_reg;
                        else if (kind_reg == KIND_ID && pos_reg == ID_DONE_POS && idcheck)
                            proven_next = 1'b1;
                        emit = 1'b1;
                    end
                    count_next = '0;
                    trim_next  = '0;
                    lead_next  = 1'b0;
                    pos_next   = '0;
                    kind_next  = KIND_NONE;
                    acc_next   = '0;
                    pend_next  = '0;
                end
            end
        end
    end

    assign result = '{frequency_hz: freq_next, mode_code: mode_next,
                      identity_proven: proven_next, overflow_error: overflow};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            trim_reg    <= '0;
            lead_reg    <= 1'b0;
            pos_reg     <= '0;
            kind_reg    <= KIND_NONE;
            acc_reg     <= '0;
            pend_reg    <= '0;
            freq_reg    <= '0;
            mode_reg    <= MODE_NONE;
            proven_reg  <= 1'b0;
            discard_reg <= 1'b0;
        end
        else if (step_en)
        begin
            count_reg   <= count_next;
            trim_reg    <= trim_next;
            lead_reg    <= lead_next;
            pos_reg     <= pos_next;
            kind_reg    <= kind_next;
            acc_reg     <= acc_next;
            pend_reg    <= pend_next;
            freq_reg    <= freq_next;
            mode_reg    <= mode_next;
            proven_reg  <= proven_next;
            discard_reg <= discard_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_LIMIT)
        else $error("byte count above limit");

    a_trim_bound: assert property (@(posedge clk) disable iff (!rst_n)
        trim_reg <= TRIM_LIMIT + 1'b1)
        else $error("trimmed count above saturation");

    a_mode_legal: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg <= MODE_MAX && mode_reg != MODE_DIGIT_CLEAR)
        else $error("illegal mode code held");

    a_proven_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        proven_reg |=> proven_reg)
        else $error("identity flag dropped");

    a_overflow_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && emit && result.overflow_error |=> count_reg == '0 && pos_reg == '0)
        else $error("overflow did not clear the frame");

endmodule

// File: rtl/crp_result_reg.sv
// Result register of the response parser: holds one item for the receiver.
// Depends on crp_pkg and crp_out_if; instantiated by cat_response_parser.
module crp_result_reg (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  crp_pkg::crp_result_t data,
    output logic                 can_load,
    crp_out_if.source            result
);
    import crp_pkg::*;

    logic        valid_reg, valid_next;
    crp_result_t data_reg;

    assign can_load   = !valid_reg || result.ready;
    assign valid_next = load || (valid_reg && !result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= data;
    end

    assign result.valid           = valid_reg;
    assign result.frequency_hz    = data_reg.frequency_hz;
    assign result.mode_code       = data_reg.mode_code;
    assign result.identity_proven = data_reg.identity_proven;
    assign result.overflow_error  = data_reg.overflow_error;

endmodule

// File: rtl/cat_response_parser.sv
// Radio control response parser, top level.
// Channels: rx (sink) takes one received byte and a chunk_end flag per item;
// result (source) gives frequency_hz, mode_code, identity_proven and
// overflow_error. cfg_write with cfg_data sets identity_check_enable.
// An item is moved when valid and ready are both high.
// Bytes outside 0x20..0x7e and bytes in the dropped rest of a chunk give no
// result. A ';' that closes a frame of acceptable length gives one result,
// and so does a byte that finds the byte store full (overflow_error set).
// Path: an accepted byte is held in the input register, parsed, and its
// result loaded into the result register. Throughput: one byte per cycle
// unless a result waits for space; the per-byte update and the shift-add
// decimal accumulator fit between the input and result registers.
// A stalled receiver holds the result register; bytes that give no result
// keep flowing, and the first one that gives a result waits for space.
// Reset clears all frame state, the frequency, mode, identity flag and the
// enable register; both registers come up empty.
// Depends on crp_pkg, crp_in_if, crp_out_if, crp_parser, crp_result_reg.
module cat_response_parser #(
    parameter int BUFFER_LIMIT = 4096,
    parameter int FRAME_LIMIT  = 128
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_write,
    input  logic      cfg_data,
    crp_in_if.sink    rx,
    crp_out_if.source result
);
    import crp_pkg::*;

    logic        stage_valid_reg;
    byte_t       byte_reg;
    logic        last_reg;
    logic        idcheck_reg;
    logic        advance;
    logic        emit;
    logic        can_load;
    crp_result_t step_result;

    assign advance  = stage_valid_reg && (!emit || can_load);
    assign rx.ready = !stage_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            idcheck_reg     <= 1'b0;
        end
        else
        begin
            if (rx.ready)
                stage_valid_reg <= rx.valid;
            if (cfg_write)
                idcheck_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            byte_reg <= rx.rx_byte;
            last_reg <= rx.chunk_end;
        end
    end

    crp_parser #(
        .BUFFER_LIMIT (BUFFER_LIMIT),
        .FRAME_LIMIT  (FRAME_LIMIT)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (advance),
        .rx_byte   (byte_reg),
        .chunk_end (last_reg),
        .idcheck   (idcheck_reg),
        .emit      (emit),
        .result    (step_result)
    );

    crp_result_reg u_result (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance && emit),
        .data     (step_result),
        .can_load (can_load),
        .result   (result)
    );

endmodule
